// ----- design/bip_byte_buffer_core_macros.svh -----
// ----------------------------------------------------------------------------
// Bip byte buffer assertion macros
// Shared concurrent assertion forms used by the checker of the buffer core.
// ----------------------------------------------------------------------------
`ifndef BIP_BYTE_BUFFER_CORE_MACROS_SVH
`define BIP_BYTE_BUFFER_CORE_MACROS_SVH

// Assertion sampled on the rising clock edge and switched off during reset.
`define BBB_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Assertion sampled on the rising clock edge that also covers reset cycles.
`define BBB_ASSERT_ALL(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

// ----- design/bbb_pkg.sv -----
// ----------------------------------------------------------------------------
// Bip byte buffer package
// Widths, request and status codes, the command record and the sequencer
// states shared by the buffer core.
// ----------------------------------------------------------------------------
`default_nettype none

package bbb_pkg;

    // Store size and limits.
    localparam int DEPTH_DEF   = 4096;
    localparam int CAP_RESET   = 4096;
    localparam int MIN_CAP     = 16;
    localparam int MAX_READ    = 64;

    // Field widths.
    localparam int LEN_W       = 13;
    localparam int CFG_W       = 13;
    localparam int BYTE_W      = 8;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int IDX_W       = $clog2(MAX_READ + 1);

    // Stream port widths.
    localparam int S_TDATA_W   = 24;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 8;
    localparam int M_TUSER_W   = 3;

    // Entries in the command queue between front and back end.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PEEK   = 2'd0,
        REQ_READ   = 2'd1,
        REQ_WRITE  = 2'd2,
        REQ_REMOVE = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_REFUSED  = 2'd1,
        ST_TOO_LONG = 2'd2
    } status_t;

    // One decoded request as it waits in the queue.
    typedef struct packed {
        req_t               req;
        logic [LEN_W-1:0]   length;
        logic [BYTE_W-1:0]  data;
        logic               len_zero;
        logic               too_long;
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_CHECK,
        S_RD_ADDR,
        S_RD_DATA,
        S_RM,
        S_CONS1,
        S_CONS2,
        S_WR_DECIDE,
        S_WR_CHECK,
        S_WR_STORE
    } bbb_state_t;

endpackage

`default_nettype wire

// ----- design/bip_byte_buffer_core.sv -----
// A request waits in the front-end queue until the single sequencer, which takes
// a new one only in S_IDLE, accepts it; results leave the registered result
// stage, read bytes first pass the registered store read. A write byte goes to
// S_WR_STORE, the first of a run via S_WR_DECIDE and S_WR_CHECK; a peek or read
// runs S_RD_CHECK, S_RD_ADDR and S_RD_DATA; read and S_RM consume in S_CONS1/2.
// Reset (aresetn low, synchronous) empties both regions; store contents stay.
// ----------------------------------------------------------------------------
// Bip byte buffer core
// Top level: a decoding front end and a command queue feed the sequencer
// that owns the byte store and the registered result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module bip_byte_buffer_core #(
    parameter int DEPTH = bbb_pkg::DEPTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Capacity register.
    input  wire logic                           cfg_wr_en,
    input  wire logic [bbb_pkg::CFG_W-1:0]      cfg_wr_data,
    // Request stream.
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [bbb_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // length[12:0], data_byte[20:13]
    input  wire logic [bbb_pkg::S_TUSER_W-1:0]  s_axis_tuser,  // req_type[1:0]
    // Result stream.
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [bbb_pkg::M_TDATA_W-1:0]       m_axis_tdata,  // data_byte_res[7:0]
    output logic [bbb_pkg::M_TUSER_W-1:0]       m_axis_tuser,  // status[1:0], has_data[2]
    output logic                                m_axis_tlast
);
    import bbb_pkg::*;

    cmd_t              cmd;
    logic              cmd_valid;
    logic              cmd_ready;
    status_t           res_status;
    logic [BYTE_W-1:0] res_byte;
    logic              res_has_data;

    bbb_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd_out       (cmd)
    );

    bbb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_in      (cmd),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_status    (res_status),
        .m_byte      (res_byte),
        .m_has_data  (res_has_data),
        .m_last      (m_axis_tlast)
    );

    // Pack the result fields onto the stream.
    assign m_axis_tdata = res_byte;
    assign m_axis_tuser = {res_has_data, res_status};

endmodule

`default_nettype wire

// ----- design/bbb_front.sv -----
// ----------------------------------------------------------------------------
// Bip byte buffer front end
// Accepts requests from the input stream, decodes them into command records
// and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bbb_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [bbb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic [bbb_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                                cmd_valid,
    input  wire logic                           cmd_ready,
    output bbb_pkg::cmd_t                       cmd_out
);
    import bbb_pkg::*;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    cmd_t              cmd_dec;
    logic              push;
    logic              pop;

    // Decode the incoming request and flag the length cases early.
    always_comb begin
        cmd_dec.req      = req_t'(s_axis_tuser);
        cmd_dec.length   = s_axis_tdata[LEN_W-1:0];
        cmd_dec.data     = s_axis_tdata[LEN_W +: BYTE_W];
        cmd_dec.len_zero = (s_axis_tdata[LEN_W-1:0] == '0);
        cmd_dec.too_long = (32'(s_axis_tdata[LEN_W-1:0]) > 32'(MAX_READ));
    end

    assign s_axis_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid     = (count_reg != '0);
    assign cmd_out       = q_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = cmd_valid && cmd_ready;

    // Queue pointers and fill level.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage carries no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cmd_dec;
        end
    end

endmodule

`default_nettype wire

// ----- design/bbb_back.sv -----
// ----------------------------------------------------------------------------
// Bip byte buffer back end
// Sequencer that carries out queued requests against the byte store, keeps
// the region bookkeeping and drives the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bbb_back #(
    parameter int DEPTH = bbb_pkg::DEPTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [bbb_pkg::CFG_W-1:0]   cfg_wr_data,
    input  wire logic                        cmd_valid,
    output logic                             cmd_ready,
    input  wire bbb_pkg::cmd_t               cmd_in,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output bbb_pkg::status_t                 m_status,
    output logic [bbb_pkg::BYTE_W-1:0]       m_byte,
    output logic                             m_has_data,
    output logic                             m_last
);
    import bbb_pkg::*;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = CNT_W + 1;
    localparam int CAP_RST_VAL = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

    // Sequencer and region bookkeeping.
    bbb_state_t         state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [CNT_W-1:0]   capacity_reg, capacity_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [CNT_W-1:0]   a_start_reg, a_start_next;
    logic [CNT_W-1:0]   a_size_reg, a_size_next;
    logic [CNT_W-1:0]   b_size_reg, b_size_next;
    logic               b_present_reg, b_present_next;
    logic [LEN_W-1:0]   wr_rem_reg, wr_rem_next;
    logic               wr_acc_reg, wr_acc_next;
    logic               wr_into_b_reg, wr_into_b_next;
    logic [CNT_W-1:0]   free_reg, free_next;
    logic [LEN_W-1:0]   n_reg, n_next;
    logic [ADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;

    // Store and its read register.
    logic [BYTE_W-1:0]  mem [DEPTH];
    logic [BYTE_W-1:0]  mem_q_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;

    // Result register.
    logic               m_valid_reg;
    status_t            m_status_reg;
    logic [BYTE_W-1:0]  m_byte_reg;
    logic               m_has_reg;
    logic               m_last_reg;
    logic               out_free;
    logic               out_load;
    status_t            out_status;
    logic [BYTE_W-1:0]  out_byte;
    logic               out_has;
    logic               out_last;

    // Shared arithmetic.
    logic [CNT_W-1:0]   a_end;
    logic [CNT_W-1:0]   a_free;
    logic [SUM_W-1:0]   stored;
    logic [CNT_W-1:0]   ra;
    logic [CNT_W-1:0]   rb;
    logic [CNT_W-1:0]   b_rest;
    logic [ADDR_W-1:0]  ptr_inc;
    logic [ADDR_W-1:0]  ptr_adv;
    logic               rd_last;
    logic               wr_last;
    logic [CNT_W-1:0]   cap_clamped;

    // Logical address to store address: add the base and wrap once.
    function automatic logic [ADDR_W-1:0] phys_f(
        input logic [CNT_W-1:0]  lg,
        input logic [ADDR_W-1:0] base,
        input logic [CNT_W-1:0]  cap
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(lg) + SUM_W'(base);
        if (sum >= SUM_W'(cap)) begin
            sum = sum - SUM_W'(cap);
        end
        return sum[ADDR_W-1:0];
    endfunction

    assign a_end   = a_start_reg + a_size_reg;
    assign a_free  = capacity_reg - a_end;
    assign stored  = SUM_W'(a_size_reg) + SUM_W'(b_size_reg);
    assign ra      = (32'(n_reg) > 32'(a_size_reg)) ? a_size_reg : CNT_W'(n_reg);
    assign rb      = (32'(n_reg) > 32'(b_size_reg)) ? b_size_reg : CNT_W'(n_reg);
    assign b_rest  = b_size_reg - rb;
    assign ptr_inc = (SUM_W'(rd_ptr_reg) + SUM_W'(1) == SUM_W'(capacity_reg)) ?
                     '0 : rd_ptr_reg + 1'b1;
    // After the last byte of A the walk continues at the start of B.
    assign ptr_adv = (32'(rd_idx_reg) + 32'd1 == 32'(a_size_reg)) ? base_reg : ptr_inc;
    assign rd_last = (32'(rd_idx_reg) + 32'd1 == 32'(cmd_reg.length));
    assign wr_last = (wr_rem_reg == LEN_W'(1));
    assign out_free = !m_valid_reg || m_ready;

    // Capacity is held within the minimum and the store depth.
    always_comb begin
        if (32'(cfg_wr_data) < 32'(MIN_CAP)) begin
            cap_clamped = CNT_W'(MIN_CAP);
        end else if (32'(cfg_wr_data) > 32'(DEPTH)) begin
            cap_clamped = CNT_W'(DEPTH);
        end else begin
            cap_clamped = CNT_W'(32'(cfg_wr_data));
        end
    end

    // Sequencer: next state, bookkeeping and result requests.
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        capacity_next  = capacity_reg;
        base_next      = base_reg;
        a_start_next   = a_start_reg;
        a_size_next    = a_size_reg;
        b_size_next    = b_size_reg;
        b_present_next = b_present_reg;
        wr_rem_next    = wr_rem_reg;
        wr_acc_next    = wr_acc_reg;
        wr_into_b_next = wr_into_b_reg;
        free_next      = free_reg;
        n_next         = n_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_idx_next    = rd_idx_reg;
        cmd_ready      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_re         = 1'b0;
        mem_raddr      = rd_ptr_reg;
        out_load       = 1'b0;
        out_status     = ST_OK;
        out_byte       = '0;
        out_has        = 1'b0;
        out_last       = 1'b1;

        case (state_reg)
            S_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    cmd_next = cmd_in;
                    // Any request other than a write byte cancels an open run.
                    if (cmd_in.req != REQ_WRITE) begin
                        wr_rem_next = '0;
                    end
                    case (cmd_in.req)
                        REQ_PEEK:   state_next = S_RD_CHECK;
                        REQ_READ:   state_next = S_RD_CHECK;
                        REQ_REMOVE: state_next = S_RM;
                        REQ_WRITE:  state_next = (wr_rem_reg == '0) ? S_WR_DECIDE : S_WR_STORE;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end

            S_RD_CHECK: begin
                if (cmd_reg.too_long) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        out_status = ST_TOO_LONG;
                        state_next = S_IDLE;
                    end
                end else if (32'(cmd_reg.length) > 32'(stored)) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        out_status = ST_REFUSED;
                        state_next = S_IDLE;
                    end
                end else if (cmd_reg.len_zero) begin
                    // An empty read still folds B into A when A is empty.
                    if (out_free) begin
                        out_load   = 1'b1;
                        n_next     = '0;
                        state_next = (cmd_reg.req == REQ_READ) ? S_CONS1 : S_IDLE;
                    end
                end else begin
                    rd_ptr_next = (a_size_reg == '0) ? base_reg :
                                  phys_f(a_start_reg, base_reg, capacity_reg);
                    rd_idx_next = '0;
                    state_next  = S_RD_ADDR;
                end
            end

            S_RD_ADDR: begin
                mem_re     = 1'b1;
                mem_raddr  = rd_ptr_reg;
                state_next = S_RD_DATA;
            end

            S_RD_DATA: begin
                // One byte per cycle while the result side keeps taking them.
                if (out_free) begin
                    out_load = 1'b1;
                    out_byte = mem_q_reg;
                    out_has  = 1'b1;
                    out_last = rd_last;
                    if (rd_last) begin
                        n_next     = cmd_reg.length;
                        state_next = (cmd_reg.req == REQ_READ) ? S_CONS1 : S_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                        rd_ptr_next = ptr_adv;
                        mem_re      = 1'b1;
                        mem_raddr   = ptr_adv;
                    end
                end
            end

            S_RM: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_next     = cmd_reg.length;
                    state_next = S_CONS1;
                end
            end

            S_CONS1: begin
                // Take what can be taken from A.
                a_start_next = a_start_reg + ra;
                a_size_next  = a_size_reg - ra;
                n_next       = n_reg - LEN_W'(ra);
                state_next   = S_CONS2;
            end

            S_CONS2: begin
                // The rest comes from B; an empty A hands over to B.
                if (a_size_reg == '0) begin
                    if (b_rest != '0) begin
                        base_next   = phys_f(rb, base_reg, capacity_reg);
                        a_size_next = b_rest;
                    end else begin
                        a_size_next = '0;
                    end
                    a_start_next   = '0;
                    b_size_next    = '0;
                    b_present_next = 1'b0;
                end else begin
                    b_size_next = b_rest;
                end
                state_next = S_IDLE;
            end

            S_WR_DECIDE: begin
                // Placement of the whole run is fixed by its first byte.
                if (b_present_reg) begin
                    wr_into_b_next = 1'b1;
                    free_next      = a_start_reg - b_size_reg;
                end else if (a_free < a_start_reg) begin
                    b_present_next = 1'b1;
                    b_size_next    = '0;
                    wr_into_b_next = 1'b1;
                    free_next      = a_start_reg;
                end else begin
                    wr_into_b_next = 1'b0;
                    free_next      = a_free;
                end
                state_next = S_WR_CHECK;
            end

            S_WR_CHECK: begin
                wr_acc_next = (32'(free_reg) >= 32'(cmd_reg.length));
                if (cmd_reg.len_zero) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    wr_rem_next = cmd_reg.length;
                    state_next  = S_WR_STORE;
                end
            end

            S_WR_STORE: begin
                if (!wr_last || out_free) begin
                    if (wr_acc_reg) begin
                        if (wr_into_b_reg) begin
                            if (b_size_reg < a_start_reg) begin
                                mem_we      = 1'b1;
                                mem_waddr   = phys_f(b_size_reg, base_reg, capacity_reg);
                                b_size_next = b_size_reg + 1'b1;
                            end
                        end else if (a_end < capacity_reg) begin
                            mem_we      = 1'b1;
                            mem_waddr   = phys_f(a_end, base_reg, capacity_reg);
                            a_size_next = a_size_reg + 1'b1;
                        end
                    end
                    wr_rem_next = wr_rem_reg - 1'b1;
                    if (wr_last) begin
                        out_load   = 1'b1;
                        out_status = wr_acc_reg ? ST_OK : ST_REFUSED;
                    end
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // A capacity write empties the store and drops any open run.
        if (cfg_wr_en) begin
            capacity_next  = cap_clamped;
            base_next      = '0;
            a_start_next   = '0;
            a_size_next    = '0;
            b_size_next    = '0;
            b_present_next = 1'b0;
            wr_rem_next    = '0;
            wr_acc_next    = 1'b0;
            wr_into_b_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            capacity_reg  <= CNT_W'(CAP_RST_VAL);
            base_reg      <= '0;
            a_start_reg   <= '0;
            a_size_reg    <= '0;
            b_size_reg    <= '0;
            b_present_reg <= 1'b0;
            wr_rem_reg    <= '0;
            wr_acc_reg    <= 1'b0;
            wr_into_b_reg <= 1'b0;
            rd_idx_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            capacity_reg  <= capacity_next;
            base_reg      <= base_next;
            a_start_reg   <= a_start_next;
            a_size_reg    <= a_size_next;
            b_size_reg    <= b_size_next;
            b_present_reg <= b_present_next;
            wr_rem_reg    <= wr_rem_next;
            wr_acc_reg    <= wr_acc_next;
            wr_into_b_reg <= wr_into_b_next;
            rd_idx_reg    <= rd_idx_next;
        end
    end

    // Working payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        free_reg   <= free_next;
        n_reg      <= n_next;
        rd_ptr_reg <= rd_ptr_next;
    end

    // Byte store: one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= cmd_reg.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    // Result register decouples the sequencer from the output stall.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= out_status;
            m_byte_reg   <= out_byte;
            m_has_reg    <= out_has;
            m_last_reg   <= out_last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_byte     = m_byte_reg;
    assign m_has_data = m_has_reg;
    assign m_last     = m_last_reg;

endmodule

`default_nettype wire

// ----- design/bbb_checker.sv -----
// ----------------------------------------------------------------------------
// Bip byte buffer checker
// Port-level assertions on the result stream of the buffer core, attached
// to the top level by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bip_byte_buffer_core_macros.svh"

module bbb_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [bbb_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  wire logic [bbb_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    input  wire logic                           m_axis_tlast
);
    import bbb_pkg::*;

    // A stalled result keeps its contents.
    `BBB_ASSERT_RST(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

    // Reset leaves no result pending.
    `BBB_ASSERT_ALL(a_reset_idle, !aresetn |=> !m_axis_tvalid, "result pending after reset")

    // A result without a byte closes its request and carries a zero byte.
    `BBB_ASSERT_RST(a_nodata_last, m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tlast && (m_axis_tdata == '0), "byte-less result not final")

    // A refused or too-long result never carries a byte.
    `BBB_ASSERT_RST(a_refused_nodata, m_axis_tvalid && (m_axis_tuser[1:0] != ST_OK) |-> !m_axis_tuser[2], "refused result carries data")

endmodule

bind bip_byte_buffer_core bbb_checker u_checker (.*);

`default_nettype wire
